@@ sv/tccw_pkg.sv @@
// shared types and constants for the text console cursor writer
// item and result structs, controller/datapath command and status groups
// no dependencies
package tccw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;

    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int CHAR_W    = 8;
    localparam int CELL_W    = 2 * CHAR_W;
    localparam int CELL_AW   = $clog2(CELL_COUNT);
    localparam int COL_CMP_W = COL_W + 2;
    localparam int ROW_CMP_W = ROW_W + 2;

    localparam logic [CHAR_W-1:0] CHAR_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BLANK  = 8'h20;
    localparam logic [CHAR_W-1:0] COLOR_RESET = 8'h02;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_PLACE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [CHAR_W-1:0] char_code;
        logic [CHAR_W-1:0] cell_color;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [CHAR_W-1:0] cell_attr;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              scrolled;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic res_load;
        logic res_read;
        logic res_scrolled;
        logic scroll_step;
        logic clear_step;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       scroll_needed;
        logic       scroll_last;
        logic       clear_last;
    } stat_t;

endpackage

@@ sv/tccw_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/tccw_ctrl.sv @@
// sequencing state machine for the console writer
// depends on tccw_pkg for the command and status groups
module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  busy
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EXEC   = 6'b000010,
        ST_READ   = 6'b000100,
        ST_SCROLL = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_CLEAR  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctrl.exec = 1'b1;
                unique case (stat.action)
                    ACT_PUT:
                    begin
                        if (stat.scroll_needed)
                        begin
                            state_next = ST_SCROLL;
                        end
                        else
                        begin
                            ctrl.res_load = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    ACT_PLACE:
                    begin
                        ctrl.res_load = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    ACT_READ:  state_next = ST_READ;
                    ACT_CLEAR: state_next = ST_CLEAR;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_READ:
            begin
                ctrl.res_load = 1'b1;
                ctrl.res_read = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_SCROLL:
            begin
                ctrl.scroll_step = 1'b1;
                if (stat.scroll_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last row copy write lands this cycle
                ctrl.res_load     = 1'b1;
                ctrl.res_scrolled = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_CLEAR:
            begin
                ctrl.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    ctrl.res_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ sv/tccw_datapath.sv @@
// item register, cursor, color register, sweep counter, screen store and result register
// depends on tccw_pkg and tccw_ram
module tccw_datapath
    import tccw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  ctrl_t             ctrl,
    input  logic              cfg_we,
    input  logic [CHAR_W-1:0] cfg_data,
    output stat_t             stat,
    output result_t           result,
    output logic              done
);

    cmd_t               cmd_reg;
    logic [ROW_W-1:0]   line_reg, line_next;
    logic [COL_W-1:0]   pos_reg, pos_next;
    logic [CHAR_W-1:0]  color_reg;
    logic [CELL_AW-1:0] cnt_reg;
    logic               wr_pend_reg;
    logic [CELL_AW-1:0] wr_addr_reg;
    result_t            result_reg;
    logic               done_reg;

    logic [COL_W:0]     pos_inc;
    logic               is_lf;
    logic               new_line;
    logic               at_bottom;
    logic               in_range;
    logic [CELL_AW-1:0] cell_addr;
    logic [CELL_AW-1:0] cursor_addr;

    logic               ram_we;
    logic [CELL_AW-1:0] ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic [CELL_AW-1:0] ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    localparam logic [CELL_AW-1:0] COLS_A = CELL_AW'(COLUMNS);

    // cursor advance for put
    assign is_lf     = (cmd_reg.char_code == CHAR_LF);
    assign pos_inc   = {1'b0, pos_reg} + 1'b1;
    assign new_line  = is_lf || (COL_CMP_W'(pos_inc) >= COL_CMP_W'(COLUMNS));
    assign at_bottom = (line_reg == ROW_W'(ROWS - 1));

    assign in_range = (COL_CMP_W'(cmd_reg.col) < COL_CMP_W'(COLUMNS))
                   && (ROW_CMP_W'(cmd_reg.row) < ROW_CMP_W'(ROWS));

    assign cell_addr   = CELL_AW'(cmd_reg.row) * COLS_A + CELL_AW'(cmd_reg.col);
    assign cursor_addr = CELL_AW'(line_reg) * COLS_A + CELL_AW'(pos_reg);

    always_comb
    begin
        line_next = line_reg;
        pos_next  = pos_reg;
        case (cmd_reg.action)
            ACT_PUT:
            begin
                if (new_line)
                begin
                    pos_next  = '0;
                    line_next = at_bottom ? line_reg : line_reg + 1'b1;
                end
                else
                begin
                    pos_next = pos_inc[COL_W-1:0];
                end
            end
            ACT_CLEAR:
            begin
                pos_next  = '0;
                line_next = '0;
            end
            default:
            begin
                pos_next  = pos_reg;
                line_next = line_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg <= cmd;
        end
        if (ctrl.scroll_step)
        begin
            wr_addr_reg <= cnt_reg;
        end
        if (ctrl.res_load)
        begin
            result_reg.cell_char  <= (ctrl.res_read && in_range) ? ram_rdata[CHAR_W-1:0] : '0;
            result_reg.cell_attr  <= (ctrl.res_read && in_range) ?
                                     ram_rdata[CELL_W-1:CHAR_W] : '0;
            result_reg.cursor_row <= ctrl.exec ? line_next : line_reg;
            result_reg.cursor_col <= ctrl.exec ? pos_next : pos_reg;
            result_reg.scrolled   <= ctrl.res_scrolled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg    <= '0;
            pos_reg     <= '0;
            color_reg   <= COLOR_RESET;
            cnt_reg     <= '0;
            wr_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (ctrl.exec)
            begin
                line_reg <= line_next;
                pos_reg  <= pos_next;
            end
            if (cfg_we)
            begin
                color_reg <= cfg_data;
            end
            cnt_reg     <= (ctrl.scroll_step || ctrl.clear_step) ? cnt_reg + 1'b1 : '0;
            wr_pend_reg <= ctrl.scroll_step;
            done_reg    <= ctrl.res_load;
        end
    end

    // one write source per cycle: clear sweep, scroll copy, put or place
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cursor_addr;
        ram_wdata = {color_reg, cmd_reg.char_code};
        if (ctrl.clear_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg;
            ram_wdata = {color_reg, CHAR_BLANK};
        end
        else if (wr_pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr_reg;
            ram_wdata = ram_rdata;
        end
        else if (ctrl.exec && (cmd_reg.action == ACT_PUT) && !is_lf)
        begin
            ram_we = 1'b1;
        end
        else if (ctrl.exec && (cmd_reg.action == ACT_PLACE) && in_range)
        begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr;
            ram_wdata = {cmd_reg.cell_color, cmd_reg.char_code};
        end
    end

    always_comb
    begin
        if (ctrl.scroll_step)
        begin
            ram_raddr = cnt_reg + COLS_A;
        end
        else if (in_range)
        begin
            ram_raddr = cell_addr;
        end
        else
        begin
            ram_raddr = '0;
        end
    end

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stat.action        = cmd_reg.action;
    assign stat.scroll_needed = new_line && at_bottom;
    assign stat.scroll_last   = (cnt_reg == CELL_AW'(SCROLL_CELLS - 1));
    assign stat.clear_last    = (cnt_reg == CELL_AW'(CELL_COUNT - 1));

    assign result = result_reg;
    assign done   = done_reg;

endmodule

@@ sv/text_console_cursor_writer.sv @@
// top level of the text console cursor writer
// joins tccw_ctrl and tccw_datapath, depends on tccw_pkg
//
// channel   direction  handshake               payload
// item      in         start & !busy           cmd (cmd_t)
// result    out        done, one-cycle strobe  result (result_t)
// config    in         cfg_valid & cfg_ready   cfg_data (text color)
//
// put and place: capture, EXEC, then the done strobe; the next item may be
//   accepted in the cycle the strobe is shown
// read: EXEC then READ, for the registered read port of the screen store
// put that scrolls: EXEC, SCROLL, then DRAIN, one cell copied per cycle
// clear: EXEC then CLEAR, one cell written per cycle
// reset clears cursor, color (to 2) and control; the store itself is not
//   cleared; results cannot be stalled, done is never held off
module text_console_cursor_writer
    import tccw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cmd_t              cmd,
    output logic              done,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CHAR_W-1:0] cfg_data
);

    ctrl_t ctrl;
    stat_t stat;

    // color writes are held off while an item is in flight
    assign cfg_ready = !busy;

    tccw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    tccw_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .ctrl     (ctrl),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .stat     (stat),
        .result   (result),
        .done     (done)
    );

    // every result belongs to an item that was in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without an item in flight");

    // an accepted item always makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    // reported cursor stays on screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.cursor_row < ROWS) && (result.cursor_col < COLUMNS)))
        else $error("cursor left the screen");

    // a scroll leaves the cursor at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.scrolled) |->
            ((result.cursor_row == ROWS - 1) && (result.cursor_col == 0)))
        else $error("scroll left cursor off the bottom row start");

endmodule
